// ===== rtl/gibase_pkg.sv =====
// Shared types and constants for the base (i-1) converter.
package gibase_pkg;

   // Width of each part field on the request channel.
   localparam int FIELD_WIDTH = 16;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_EMIT
   } gibase_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic step;
      logic emit_start;
      logic emit_en;
   } gibase_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic more;
      logic emit_done;
   } gibase_status_type;

endpackage

// ===== rtl/gibase_if.sv =====
// Request and response channel interfaces of the base (i-1) converter.
interface gibase_req_if import gibase_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic signed [FIELD_WIDTH-1:0] real_part;
   logic signed [FIELD_WIDTH-1:0] imag_part;

   modport source (output valid, output real_part, output imag_part, input ready);
   modport sink (input valid, input real_part, input imag_part, output ready);
endinterface

interface gibase_rsp_if;
   logic valid;
   logic ready;
   logic digit;
   logic last;

   modport source (output valid, output digit, output last, input ready);
   modport sink (input valid, input digit, input last, output ready);
endinterface

// ===== rtl/gibase_ram.sv =====
// Generic single write port RAM with one registered read port.
module gibase_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port; the data holds while no read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/gibase_dp.sv =====
// Datapath: the division step, the digit buffer and the output register.
module gibase_dp import gibase_pkg::*; #(
   parameter int MAX_DIGITS = 64,
   parameter int PART_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  gibase_cmd_type                cmd,
   output gibase_status_type             status,
   input  logic signed [FIELD_WIDTH-1:0] real_part,
   input  logic signed [FIELD_WIDTH-1:0] imag_part,
   gibase_rsp_if.source                  rsp
);

   localparam int WORK_W = PART_WIDTH + 2;
   localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
   localparam int ADDR_W = $clog2(MAX_DIGITS);
   localparam int EXT_W  = (PART_WIDTH > FIELD_WIDTH) ? PART_WIDTH : FIELD_WIDTH;

   logic signed [WORK_W-1:0] work_real_ff, work_real_in;
   logic signed [WORK_W-1:0] work_imag_ff, work_imag_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CNT_W-1:0]         left_ff, left_in;
   logic                     pend_ff, pend_in;
   logic                     pend_last_ff, pend_last_in;
   logic                     out_valid_ff, out_valid_in;
   logic                     out_digit_ff, out_digit_in;
   logic                     out_last_ff, out_last_in;

   logic [EXT_W-1:0]         real_ext;
   logic [EXT_W-1:0]         imag_ext;
   logic signed [WORK_W-1:0] real_load;
   logic signed [WORK_W-1:0] imag_load;
   logic                     digit_bit;
   logic [WORK_W:0]          sum_real;
   logic [WORK_W:0]          sum_imag;
   logic [CNT_W-1:0]         left_dec;
   logic                     load_out;
   logic                     issue;
   logic                     ram_bit;

   // Take the low PART_WIDTH bits of each field and sign extend them.
   assign real_ext  = EXT_W'($unsigned(real_part));
   assign imag_ext  = EXT_W'($unsigned(imag_part));
   assign real_load = WORK_W'(signed'(real_ext[PART_WIDTH-1:0]));
   assign imag_load = WORK_W'(signed'(imag_ext[PART_WIDTH-1:0]));

   // One division by (i-1): both sums are even, so a shift is exact.
   assign digit_bit = work_real_ff[0] ^ work_imag_ff[0];
   assign sum_real  = (WORK_W+1)'(work_imag_ff) - (WORK_W+1)'(work_real_ff)
                      + (WORK_W+1)'(digit_bit);
   assign sum_imag  = (WORK_W+1)'(0) - (WORK_W+1)'(work_real_ff)
                      - (WORK_W+1)'(work_imag_ff) + (WORK_W+1)'(digit_bit);

   // A zero number still produces its single zero digit on the first step.
   assign status.more = ((count_ff == '0) || (work_real_ff != '0) || (work_imag_ff != '0))
                        && (count_ff < CNT_W'(MAX_DIGITS));
   assign status.emit_done = (left_ff == '0) && !pend_ff;

   // Readout: one read in flight ahead of the output register.
   assign left_dec = left_ff - CNT_W'(1);
   assign load_out = pend_ff && (!out_valid_ff || rsp.ready);
   assign issue    = cmd.emit_en && (left_ff != '0) && (!pend_ff || load_out);

   gibase_ram #(
      .WIDTH (1),
      .DEPTH (MAX_DIGITS)
   ) u_digit_store (
      .clock   (clock),
      .wr_en   (cmd.step),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (digit_bit),
      .rd_en   (issue),
      .rd_addr (left_dec[ADDR_W-1:0]),
      .rd_data (ram_bit)
   );

   // Next state of the working parts and the digit count.
   always_comb begin
      work_real_in = work_real_ff;
      work_imag_in = work_imag_ff;
      count_in     = count_ff;
      if (cmd.load) begin
         work_real_in = real_load;
         work_imag_in = imag_load;
         count_in     = '0;
      end else if (cmd.step) begin
         work_real_in = sum_real[WORK_W:1];
         work_imag_in = sum_imag[WORK_W:1];
         count_in     = count_ff + CNT_W'(1);
      end
   end

   // Next state of the readout pipeline.
   always_comb begin
      left_in      = left_ff;
      pend_in      = pend_ff;
      pend_last_in = pend_last_ff;
      out_valid_in = out_valid_ff;
      out_digit_in = out_digit_ff;
      out_last_in  = out_last_ff;
      if (cmd.emit_start) begin
         left_in = count_ff;
      end else if (issue) begin
         left_in = left_dec;
      end
      if (issue) begin
         pend_in      = 1'b1;
         pend_last_in = (left_ff == CNT_W'(1));
      end else if (load_out) begin
         pend_in = 1'b0;
      end
      if (load_out) begin
         out_valid_in = 1'b1;
         out_digit_in = ram_bit;
         out_last_in  = pend_last_ff;
      end else if (out_valid_ff && rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         work_real_ff <= '0;
         work_imag_ff <= '0;
         count_ff     <= '0;
         left_ff      <= '0;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         work_real_ff <= work_real_in;
         work_imag_ff <= work_imag_in;
         count_ff     <= count_in;
         left_ff      <= left_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      pend_last_ff <= pend_last_in;
      out_digit_ff <= out_digit_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.digit = out_digit_ff;
   assign rsp.last  = out_last_ff;

endmodule

// ===== rtl/gibase_ctrl.sv =====
// Controller: sequences load, conversion steps and digit readout.
module gibase_ctrl import gibase_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  gibase_status_type status,
   output gibase_cmd_type    cmd,
   output gibase_state_type  state
);

   gibase_state_type state_ff, state_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            if (!status.more) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.emit_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs. No request is taken while reset is held.
   always_comb begin
      req_ready      = 1'b0;
      cmd            = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = !reset;
            cmd.load  = req_valid && !reset;
         end
         ST_CONVERT: begin
            cmd.step       = status.more;
            cmd.emit_start = !status.more;
         end
         ST_EMIT: begin
            cmd.emit_en = 1'b1;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign state = state_ff;

endmodule

// ===== rtl/gaussian_int_to_base_i_minus_1_top.sv =====
// Top level of the Gaussian integer to base (i-1) converter.
//
// The request channel (req_if) carries one Gaussian integer as a real and an
// imaginary part, two's complement, of which the low PART_WIDTH bits count.
// The response channel (rsp_if) returns the base (i-1) digits one per
// response, most significant first, with last set on the final digit. Zero
// gives the single digit 0.
// A request is taken only when the block is idle. It then runs one division
// step per cycle, storing each digit in a small RAM, and then reads the RAM
// back into the output register one digit per cycle while the receiver
// accepts. A number has N digits; N is at most MAX_DIGITS and up to about
// 2 * PART_WIDTH + 8 for full scale inputs.
// When the receiver stalls, the output register and one pending RAM read
// hold their digits and readout pauses; nothing is dropped.
// Synchronous reset returns the controller to idle and empties the output.
module gaussian_int_to_base_i_minus_1_top import gibase_pkg::*; #(
   parameter int MAX_DIGITS = 64,
   parameter int PART_WIDTH = 16
) (
   input  logic         clock,
   input  logic         reset,
   gibase_req_if.sink   req_if,
   gibase_rsp_if.source rsp_if
);

   gibase_cmd_type    cmd;
   gibase_status_type status;
   gibase_state_type  state;

   // Controller.
   gibase_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd),
      .state     (state)
   );

   // Datapath.
   gibase_dp #(
      .MAX_DIGITS (MAX_DIGITS),
      .PART_WIDTH (PART_WIDTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .real_part (req_if.real_part),
      .imag_part (req_if.imag_part),
      .rsp       (rsp_if)
   );

`ifndef ASSERT_OFF
   // At most one command is issued in any cycle.
   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.step, cmd.emit_start, cmd.emit_en}))
      else $error("controller issued overlapping commands");

   // Readout starts only once the conversion has finished.
   a_emit_after_convert: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_start |-> !status.more)
      else $error("readout started during conversion");

   // A freshly loaded number always needs at least one step.
   a_first_step: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (status.more && state == ST_CONVERT))
      else $error("no conversion step after load");

   // Readout ends only after at least one digit has been moved.
   a_emit_not_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_start |=> !status.emit_done)
      else $error("readout started with no digits");
`endif

endmodule
